FILE: hdl/crau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crau_pkg: shared constants for the checked rational arithmetic unit
// Operation codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package crau_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int EXP_LIMIT_DEF = 32;

	localparam int FIELD_BITS = 64;
	localparam int DEN_BITS   = 63;
	localparam int CMD_BITS   = 3;
	localparam int EXP_BITS   = 7;

	typedef logic [CMD_BITS-1:0] cmd_t;

	localparam cmd_t CMD_MUL  = 3'd0;
	localparam cmd_t CMD_ADD  = 3'd1;
	localparam cmd_t CMD_SUB  = 3'd2;
	localparam cmd_t CMD_DIV  = 3'd3;
	localparam cmd_t CMD_POW  = 3'd4;
	localparam cmd_t CMD_NORM = 3'd5;

endpackage
`default_nettype wire

FILE: hdl/crau_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crau_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crau_div #(
	parameter int W = crau_pkg::WORD_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic      [W-1:0] quo,
	output logic      [W-1:0] rem,
	output logic              done
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    sh;
	logic [W:0]    diff;

	assign sh   = {rem_q, quo_q[W-1]};
	assign diff = sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// top bit of diff set means the trial subtract borrowed
			quo_q <= {quo_q[W-2:0], ~diff[W]};
			rem_q <= diff[W] ? sh[W-1:0] : diff[W-1:0];
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule
`default_nettype wire

FILE: hdl/crau_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crau_mul: bit-serial unsigned multiplier
// Shift-and-add, one multiplier bit per cycle, full 2W-bit product.
// ----------------------------------------------------------------------------
module crau_mul #(
	parameter int W = crau_pkg::WORD_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] op_a,
	input  wire logic [W-1:0] op_b,
	output logic      [W-1:0] prod_hi,
	output logic      [W-1:0] prod_lo,
	output logic              done
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  hi_q;
	logic [W-1:0]  lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= op_a;
			hi_q <= '0;
			lo_q <= op_b;
		end else if (busy_q) begin
			hi_q <= sum[W:1];
			lo_q <= {sum[0], lo_q[W-1:1]};
		end
	end

	assign prod_hi = hi_q;
	assign prod_lo = lo_q;
	assign done    = done_q;

endmodule
`default_nettype wire

FILE: hdl/checked_rational_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// checked_rational_arithmetic_unit: normalized fraction arithmetic
// Multiply, add, subtract, divide, power and normalize of signed fractions,
// with overflow checking and reduction to lowest terms.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid/in_ready carries cmd, a_num, a_den, b_num, b_den
//   and power_exp; output channel out_valid/out_ready carries res_num,
//   res_den and ok. One result beat for every input beat, in order.
// - one item is worked on at a time. Multiplies and divisions go through a
//   shared bit-serial divider and a bit-serial multiplier. A gcd is found by
//   Euclid, one division per step, and a 64-bit gcd takes at most about 92
//   steps, so the gcds set the latency. A bad operation code or a zero a_den
//   ends without them; a power takes at most nine fraction multiplies for an
//   exponent of magnitude up to 32.
// - the result is held in an output register; the next input beat is taken
//   while it waits. A finished item waits for that register to free up
//   when the receiver stalls.
// - reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module checked_rational_arithmetic_unit #(
	parameter int WORD_BITS = crau_pkg::WORD_BITS_DEF,
	parameter int EXP_LIMIT = crau_pkg::EXP_LIMIT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [crau_pkg::CMD_BITS-1:0]       cmd,
	input  wire logic signed [crau_pkg::FIELD_BITS-1:0] a_num,
	input  wire logic signed [crau_pkg::FIELD_BITS-1:0] a_den,
	input  wire logic signed [crau_pkg::FIELD_BITS-1:0] b_num,
	input  wire logic signed [crau_pkg::FIELD_BITS-1:0] b_den,
	input  wire logic signed [crau_pkg::EXP_BITS-1:0]   power_exp,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [crau_pkg::FIELD_BITS-1:0]   res_num,
	output logic        [crau_pkg::DEN_BITS-1:0]     res_den,
	output logic                                     ok
);

	localparam int W  = WORD_BITS;
	localparam int FB = crau_pkg::FIELD_BITS;
	localparam int DB = crau_pkg::DEN_BITS;
	localparam int EB = crau_pkg::EXP_BITS;
	localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE  = W'(1);

	typedef enum logic [5:0] {
		S_IDLE, S_LA, S_LA2, S_LB, S_LB2,
		S_PW0, S_PWLOOP, S_PWM1, S_PWSHIFT, S_PWM2,
		S_FM0, S_FM1, S_FM2, S_FM3, S_FM4, S_FM5, S_FM6, S_FM7, S_FM8,
		S_FA0, S_FA1, S_FA2, S_FA3, S_FA4, S_FA5, S_FA6, S_FA7, S_FA8,
		S_RD0, S_RD1, S_RD2, S_RD3,
		S_GLOOP, S_GSTEP, S_WAIT, S_OK, S_FAIL, S_FIN
	} state_t;

	state_t state_q, wait_ret_q, gcd_ret_q, red_ret_q, fm_ret_q;

	crau_pkg::cmd_t cmd_q;
	logic [FB-1:0]  an_q, ad_q, bn_q, bd_q;
	logic [EB-1:0]  exp_q;
	logic [EB-1:0]  rem_q;

	// fraction slots: x, y operands of multiply/add, r reduce, p and f power
	logic         xneg_q, yneg_q, rneg_q, pneg_q, fneg_q;
	logic [W-1:0] xn_q, xd_q, yn_q, yd_q, rn_q, rd_q, pn_q, pd_q, fn_q, fd_q;
	logic [W-1:0] ga_q, gb_q;
	logic         brw_q;
	logic         fin_ok_q;

	logic         div_start_q, mul_start_q;
	logic [W-1:0] div_a_q, div_b_q, mul_a_q, mul_b_q;
	logic [W-1:0] div_quo, div_rem, mul_hi, mul_lo;
	logic         div_done, mul_done;

	logic          out_valid_q, ok_q;
	logic [FB-1:0] res_num_q;
	logic [DB-1:0] res_den_q;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? ('0 - v) : v;
	endfunction

	logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
	logic         an_neg, ad_neg, bn_neg, bd_neg;

	assign an_neg = an_q[W-1];
	assign ad_neg = ad_q[W-1];
	assign bn_neg = bn_q[W-1];
	assign bd_neg = bd_q[W-1];
	assign an_mag = mag_of(an_q[W-1:0]);
	assign ad_mag = mag_of(ad_q[W-1:0]);
	assign bn_mag = mag_of(bn_q[W-1:0]);
	assign bd_mag = mag_of(bd_q[W-1:0]);

	// product range checks against the signed word
	logic mul_nz, ovf_pos, ovf_neg;
	assign mul_nz  = (|mul_hi) || (|mul_lo);
	assign ovf_pos = (|mul_hi) || mul_lo[W-1];
	assign ovf_neg = (|mul_hi) || (mul_lo[W-1] && (|mul_lo[W-2:0]));

	// one adder: sum on equal signs, difference otherwise
	logic       same_sgn;
	logic [W:0] as_b, as_r;
	logic       sum_ovf;
	assign same_sgn = (xneg_q == yneg_q);
	assign as_b     = same_sgn ? {1'b0, yn_q} : ~{1'b0, yn_q};
	assign as_r     = {1'b0, xn_q} + as_b + (W+1)'(!same_sgn);
	assign sum_ovf  = xneg_q ? (as_r[W] || (as_r[W-1] && (|as_r[W-2:0])))
	                         : (as_r[W] || as_r[W-1]);

	logic          eneg;
	logic [EB-1:0] pw_rem;
	assign eneg   = exp_q[EB-1];
	assign pw_rem = eneg ? (EB'(0) - exp_q) : exp_q;

	logic [FB-1:0] enc_num;
	assign enc_num = rneg_q ? (FB'(0) - FB'(rn_q)) : FB'(rn_q);

	crau_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.quo      (div_quo),
		.rem      (div_rem),
		.done     (div_done)
	);

	crau_mul #(.W(W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.op_a    (mul_a_q),
		.op_b    (mul_b_q),
		.prod_hi (mul_hi),
		.prod_lo (mul_lo),
		.done    (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_ret_q  <= S_IDLE;
			gcd_ret_q   <= S_IDLE;
			red_ret_q   <= S_IDLE;
			fm_ret_q    <= S_IDLE;
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						an_q    <= a_num;
						ad_q    <= a_den;
						bn_q    <= b_num;
						bd_q    <= b_den;
						exp_q   <= power_exp;
						state_q <= S_LA;
					end
				end
				S_LA: begin
					if (cmd_q > crau_pkg::CMD_NORM) begin
						state_q <= S_FAIL;
					end else if (ad_mag == '0) begin
						if (cmd_q == crau_pkg::CMD_NORM) begin
							// zero denominator passes through on normalize
							rneg_q   <= an_neg;
							rn_q     <= an_mag;
							rd_q     <= '0;
							fin_ok_q <= 1'b1;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_FAIL;
						end
					end else if (ad_neg && ((an_neg && an_mag == SIGN) || ad_mag == SIGN)) begin
						state_q <= S_FAIL;
					end else begin
						rneg_q    <= ad_neg ? (!an_neg && an_mag != '0) : an_neg;
						rn_q      <= an_mag;
						rd_q      <= ad_mag;
						red_ret_q <= S_LA2;
						state_q   <= S_RD0;
					end
				end
				S_LA2: begin
					xneg_q <= rneg_q;
					xn_q   <= rn_q;
					xd_q   <= rd_q;
					if (cmd_q == crau_pkg::CMD_NORM) begin
						state_q <= S_OK;
					end else if (cmd_q == crau_pkg::CMD_POW) begin
						state_q <= S_PW0;
					end else begin
						state_q <= S_LB;
					end
				end
				S_LB: begin
					if (bd_mag == '0) begin
						state_q <= S_FAIL;
					end else if (bd_neg && ((bn_neg && bn_mag == SIGN) || bd_mag == SIGN)) begin
						state_q <= S_FAIL;
					end else begin
						rneg_q    <= bd_neg ? (!bn_neg && bn_mag != '0) : bn_neg;
						rn_q      <= bn_mag;
						rd_q      <= bd_mag;
						red_ret_q <= S_LB2;
						state_q   <= S_RD0;
					end
				end
				S_LB2: begin
					yneg_q   <= rneg_q;
					yn_q     <= rn_q;
					yd_q     <= rd_q;
					fm_ret_q <= S_OK;
					case (cmd_q)
						crau_pkg::CMD_MUL: state_q <= S_FM0;
						crau_pkg::CMD_ADD: state_q <= S_FA0;
						crau_pkg::CMD_SUB: begin
							if (rneg_q && rn_q == SIGN) begin
								state_q <= S_FAIL;
							end else begin
								yneg_q  <= !rneg_q && rn_q != '0;
								state_q <= S_FA0;
							end
						end
						crau_pkg::CMD_DIV: begin
							if (rn_q == '0 || (rneg_q && rn_q == SIGN)) begin
								state_q <= S_FAIL;
							end else begin
								// reciprocal of a reduced fraction stays reduced
								yn_q    <= rd_q;
								yd_q    <= rn_q;
								state_q <= S_FM0;
							end
						end
						default: state_q <= S_FAIL;
					endcase
				end
				S_PW0: begin
					if (pw_rem > EB'(EXP_LIMIT)) begin
						state_q <= S_FAIL;
					end else if (pw_rem == '0) begin
						rneg_q  <= 1'b0;
						rn_q    <= ONE;
						rd_q    <= ONE;
						state_q <= S_OK;
					end else if (eneg && (xn_q == '0 || (xneg_q && xn_q == SIGN))) begin
						state_q <= S_FAIL;
					end else begin
						fneg_q  <= xneg_q;
						fn_q    <= eneg ? xd_q : xn_q;
						fd_q    <= eneg ? xn_q : xd_q;
						pneg_q  <= 1'b0;
						pn_q    <= ONE;
						pd_q    <= ONE;
						rem_q   <= pw_rem;
						state_q <= S_PWLOOP;
					end
				end
				S_PWLOOP: begin
					if (rem_q[0]) begin
						xneg_q   <= pneg_q;
						xn_q     <= pn_q;
						xd_q     <= pd_q;
						yneg_q   <= fneg_q;
						yn_q     <= fn_q;
						yd_q     <= fd_q;
						fm_ret_q <= S_PWM1;
						state_q  <= S_FM0;
					end else begin
						state_q <= S_PWSHIFT;
					end
				end
				S_PWM1: begin
					pneg_q  <= rneg_q;
					pn_q    <= rn_q;
					pd_q    <= rd_q;
					state_q <= S_PWSHIFT;
				end
				S_PWSHIFT: begin
					rem_q <= rem_q >> 1;
					if (rem_q[EB-1:1] != '0) begin
						xneg_q   <= fneg_q;
						xn_q     <= fn_q;
						xd_q     <= fd_q;
						yneg_q   <= fneg_q;
						yn_q     <= fn_q;
						yd_q     <= fd_q;
						fm_ret_q <= S_PWM2;
						state_q  <= S_FM0;
					end else begin
						// last exponent bit is always set, so r holds the power
						state_q <= S_OK;
					end
				end
				S_PWM2: begin
					fneg_q  <= rneg_q;
					fn_q    <= rn_q;
					fd_q    <= rd_q;
					state_q <= S_PWLOOP;
				end
				// fraction multiply with cross cancellation
				S_FM0: begin
					ga_q      <= xn_q;
					gb_q      <= yd_q;
					gcd_ret_q <= S_FM1;
					state_q   <= S_GLOOP;
				end
				S_FM1: begin
					div_start_q <= 1'b1;
					div_a_q     <= xn_q;
					div_b_q     <= ga_q;
					wait_ret_q  <= S_FM2;
					state_q     <= S_WAIT;
				end
				S_FM2: begin
					xn_q        <= div_quo;
					div_start_q <= 1'b1;
					div_a_q     <= yd_q;
					div_b_q     <= ga_q;
					wait_ret_q  <= S_FM3;
					state_q     <= S_WAIT;
				end
				S_FM3: begin
					yd_q      <= div_quo;
					ga_q      <= yn_q;
					gb_q      <= xd_q;
					gcd_ret_q <= S_FM4;
					state_q   <= S_GLOOP;
				end
				S_FM4: begin
					div_start_q <= 1'b1;
					div_a_q     <= yn_q;
					div_b_q     <= ga_q;
					wait_ret_q  <= S_FM5;
					state_q     <= S_WAIT;
				end
				S_FM5: begin
					yn_q        <= div_quo;
					div_start_q <= 1'b1;
					div_a_q     <= xd_q;
					div_b_q     <= ga_q;
					wait_ret_q  <= S_FM6;
					state_q     <= S_WAIT;
				end
				S_FM6: begin
					xd_q        <= div_quo;
					mul_start_q <= 1'b1;
					mul_a_q     <= xn_q;
					mul_b_q     <= yn_q;
					wait_ret_q  <= S_FM7;
					state_q     <= S_WAIT;
				end
				S_FM7: begin
					if ((xneg_q ^ yneg_q) ? ovf_neg : ovf_pos) begin
						state_q <= S_FAIL;
					end else begin
						rn_q        <= mul_lo;
						rneg_q      <= (xneg_q ^ yneg_q) && mul_nz;
						mul_start_q <= 1'b1;
						mul_a_q     <= xd_q;
						mul_b_q     <= yd_q;
						wait_ret_q  <= S_FM8;
						state_q     <= S_WAIT;
					end
				end
				S_FM8: begin
					if (ovf_pos) begin
						state_q <= S_FAIL;
					end else begin
						rd_q      <= mul_lo;
						red_ret_q <= fm_ret_q;
						state_q   <= S_RD0;
					end
				end
				// fraction add over the common denominator
				S_FA0: begin
					ga_q      <= xd_q;
					gb_q      <= yd_q;
					gcd_ret_q <= S_FA1;
					state_q   <= S_GLOOP;
				end
				S_FA1: begin
					div_start_q <= 1'b1;
					div_a_q     <= yd_q;
					div_b_q     <= ga_q;
					wait_ret_q  <= S_FA2;
					state_q     <= S_WAIT;
				end
				S_FA2: begin
					yd_q        <= div_quo;
					div_start_q <= 1'b1;
					div_a_q     <= xd_q;
					div_b_q     <= ga_q;
					wait_ret_q  <= S_FA3;
					state_q     <= S_WAIT;
				end
				S_FA3: begin
					gb_q        <= div_quo;
					mul_start_q <= 1'b1;
					mul_a_q     <= xn_q;
					mul_b_q     <= yd_q;
					wait_ret_q  <= S_FA4;
					state_q     <= S_WAIT;
				end
				S_FA4: begin
					if (xneg_q ? ovf_neg : ovf_pos) begin
						state_q <= S_FAIL;
					end else begin
						xn_q        <= mul_lo;
						xneg_q      <= xneg_q && mul_nz;
						mul_start_q <= 1'b1;
						mul_a_q     <= yn_q;
						mul_b_q     <= gb_q;
						wait_ret_q  <= S_FA5;
						state_q     <= S_WAIT;
					end
				end
				S_FA5: begin
					if (yneg_q ? ovf_neg : ovf_pos) begin
						state_q <= S_FAIL;
					end else begin
						yn_q        <= mul_lo;
						yneg_q      <= yneg_q && mul_nz;
						mul_start_q <= 1'b1;
						mul_a_q     <= xd_q;
						mul_b_q     <= yd_q;
						wait_ret_q  <= S_FA6;
						state_q     <= S_WAIT;
					end
				end
				S_FA6: begin
					if (ovf_pos) begin
						state_q <= S_FAIL;
					end else begin
						rd_q    <= mul_lo;
						state_q <= S_FA7;
					end
				end
				S_FA7: begin
					if (same_sgn) begin
						if (sum_ovf) begin
							state_q <= S_FAIL;
						end else begin
							rn_q    <= as_r[W-1:0];
							rneg_q  <= xneg_q;
							brw_q   <= 1'b0;
							state_q <= S_FA8;
						end
					end else begin
						rn_q    <= as_r[W-1:0];
						rneg_q  <= as_r[W] ? yneg_q : xneg_q;
						brw_q   <= as_r[W];
						state_q <= S_FA8;
					end
				end
				S_FA8: begin
					if (brw_q) begin
						rn_q <= '0 - rn_q;
					end
					// a zero sum loses its sign in the reduce step
					red_ret_q <= S_OK;
					state_q   <= S_RD0;
				end
				// reduce r to lowest terms
				S_RD0: begin
					ga_q      <= rn_q;
					gb_q      <= rd_q;
					gcd_ret_q <= S_RD1;
					state_q   <= S_GLOOP;
				end
				S_RD1: begin
					div_start_q <= 1'b1;
					div_a_q     <= rn_q;
					div_b_q     <= ga_q;
					wait_ret_q  <= S_RD2;
					state_q     <= S_WAIT;
				end
				S_RD2: begin
					rn_q        <= div_quo;
					div_start_q <= 1'b1;
					div_a_q     <= rd_q;
					div_b_q     <= ga_q;
					wait_ret_q  <= S_RD3;
					state_q     <= S_WAIT;
				end
				S_RD3: begin
					rd_q    <= div_quo;
					rneg_q  <= rneg_q && rn_q != '0;
					state_q <= red_ret_q;
				end
				// euclid on ga, gb; result left in ga
				S_GLOOP: begin
					if (gb_q == '0) begin
						state_q <= gcd_ret_q;
					end else begin
						div_start_q <= 1'b1;
						div_a_q     <= ga_q;
						div_b_q     <= gb_q;
						wait_ret_q  <= S_GSTEP;
						state_q     <= S_WAIT;
					end
				end
				S_GSTEP: begin
					ga_q    <= gb_q;
					gb_q    <= div_rem;
					state_q <= S_GLOOP;
				end
				S_WAIT: begin
					if (div_done || mul_done) begin
						state_q <= wait_ret_q;
					end
				end
				S_OK: begin
					fin_ok_q <= 1'b1;
					state_q  <= S_FIN;
				end
				S_FAIL: begin
					fin_ok_q <= 1'b0;
					state_q  <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						res_num_q   <= fin_ok_q ? enc_num : '0;
						res_den_q   <= fin_ok_q ? DB'(rd_q) : '0;
						ok_q        <= fin_ok_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign ok        = ok_q;

`ifndef SYNTHESIS
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in progress");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (res_num == '0 && res_den == '0))
		else $error("failure beat carries a nonzero fraction");

	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result beat raised outside the finish step");
`endif

endmodule
`default_nettype wire
